// ===== hw/rtl/lsr_pkg.sv =====
// lsr_pkg: shared types and constants for the LIFO stack with reverse.
// No dependencies; used by lsr_ctrl, lsr_mem and lifo_stack_with_reverse.
`default_nettype none

package lsr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_SIZE    = 3'd3,
        CMD_REVERSE = 3'd4,
        CMD_DUMP    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_RESP,
        ST_REV_RD_LO,
        ST_REV_RD_HI,
        ST_REV_WR_LO,
        ST_REV_WR_HI,
        ST_DUMP,
        ST_DUMP_LAST
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/lifo_stack_with_reverse.sv =====
// lifo_stack_with_reverse: top level, stack of signed words with reverse and dump.
// Depends on lsr_pkg, lsr_mem and lsr_ctrl.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------------
//   command  | start / busy              | i_cmd, i_push_value
//   result   | o_result_valid (strobe)   | o_data_word, o_entry_index, o_fill_level,
//            |                           | o_status, o_last_result
//
// An item is taken when start is high and busy is low; each result is registered and
// appears in the cycle after the operation finishes. Push, size, unused codes, reverse
// of fewer than two entries and every empty or full case leave busy low, so the next
// item can be taken straight away. Pop and peek wait on the registered memory read.
// Reverse swaps pairs through the one read port and one write port: read low, read
// high, write low, write high. Dump streams one entry per cycle once the first read lands.
// Synchronous active-low reset clears the count and sequencer; storage is not cleared.
// The receiver cannot stall, so results go out as soon as they are formed.
`default_nettype none

module lifo_stack_with_reverse #(
    parameter int DEPTH = lsr_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        i_cmd,
    input  wire logic signed [lsr_pkg::WORD_W-1:0] i_push_value,
    output logic                                   o_result_valid,
    output logic signed [lsr_pkg::WORD_W-1:0]      o_data_word,
    output logic [$clog2(DEPTH)-1:0]               o_entry_index,
    output logic [$clog2(DEPTH+1)-1:0]             o_fill_level,
    output logic [1:0]                             o_status,
    output logic                                   o_last_result
);

    localparam int AW = $clog2(DEPTH);

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [lsr_pkg::WORD_W-1:0] mem_wdata;
    logic [AW-1:0]                     mem_raddr;
    logic signed [lsr_pkg::WORD_W-1:0] mem_rdata;

    lsr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_push_value   (i_push_value),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_result_valid (o_result_valid),
        .o_data_word    (o_data_word),
        .o_entry_index  (o_entry_index),
        .o_fill_level   (o_fill_level),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

    lsr_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lsr_mem.sv =====
// lsr_mem: stack storage, one write port and one read port, read data registered.
// Depends on lsr_pkg for the word width.
`default_nettype none

module lsr_mem #(
    parameter int DEPTH = lsr_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  wire logic signed [lsr_pkg::WORD_W-1:0] i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic signed [lsr_pkg::WORD_W-1:0]      o_rdata
);

    logic signed [lsr_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lsr_ctrl.sv =====
// lsr_ctrl: command sequencer; keeps the entry count, drives the memory ports
// and the registered result. Depends on lsr_pkg.
`default_nettype none

module lsr_ctrl #(
    parameter int DEPTH = lsr_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        i_cmd,
    input  wire logic signed [lsr_pkg::WORD_W-1:0] i_push_value,
    // memory side
    output logic                                   o_mem_we,
    output logic [$clog2(DEPTH)-1:0]               o_mem_waddr,
    output logic signed [lsr_pkg::WORD_W-1:0]      o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]               o_mem_raddr,
    input  wire logic signed [lsr_pkg::WORD_W-1:0] i_mem_rdata,
    // result
    output logic                                   o_result_valid,
    output logic signed [lsr_pkg::WORD_W-1:0]      o_data_word,
    output logic [$clog2(DEPTH)-1:0]               o_entry_index,
    output logic [$clog2(DEPTH+1)-1:0]             o_fill_level,
    output logic [1:0]                             o_status,
    output logic                                   o_last_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lsr_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_lo, n_lo;
    logic [AW-1:0]   r_hi, n_hi;
    logic [AW-1:0]   r_pidx, n_pidx;
    logic            r_pend, n_pend;
    logic signed [lsr_pkg::WORD_W-1:0] r_tmp, n_tmp;

    logic                              r_valid, n_valid;
    logic signed [lsr_pkg::WORD_W-1:0] r_data, n_data;
    logic [AW-1:0]                     r_idx, n_idx;
    logic [CW-1:0]                     r_fill, n_fill;
    lsr_pkg::t_status                  r_status, n_status;
    logic                              r_last, n_last;

    logic [AW-1:0] top_addr;
    logic [AW-1:0] lo_inc;
    logic [AW-1:0] hi_dec;
    logic          is_empty;
    logic          is_full;

    assign top_addr = AW'(r_count - CW'(1));
    assign lo_inc   = r_lo + AW'(1);
    assign hi_dec   = r_hi - AW'(1);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsr_pkg::ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_pidx   <= n_pidx;
        r_tmp    <= n_tmp;
        r_data   <= n_data;
        r_idx    <= n_idx;
        r_fill   <= n_fill;
        r_status <= n_status;
        r_last   <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pidx      = r_pidx;
        n_pend      = 1'b0;
        n_tmp       = r_tmp;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_lo;
        o_mem_wdata = r_tmp;
        o_mem_raddr = r_lo;
        n_valid     = 1'b0;
        n_data      = '0;
        n_idx       = '0;
        n_fill      = r_count;
        n_status    = lsr_pkg::STAT_OK;
        n_last      = 1'b1;

        unique case (r_state)
            lsr_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (lsr_pkg::t_cmd'(i_cmd))
                        lsr_pkg::CMD_PUSH: begin
                            n_valid = 1'b1;
                            if (is_full) begin
                                n_status = lsr_pkg::STAT_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_count);
                                o_mem_wdata = i_push_value;
                                n_count     = r_count + CW'(1);
                                n_fill      = r_count + CW'(1);
                            end
                        end
                        lsr_pkg::CMD_POP: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = lsr_pkg::STAT_EMPTY;
                            end else begin
                                o_mem_raddr = top_addr;
                                n_count     = r_count - CW'(1);
                                n_state     = lsr_pkg::ST_RD_RESP;
                            end
                        end
                        lsr_pkg::CMD_PEEK: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = lsr_pkg::STAT_EMPTY;
                            end else begin
                                o_mem_raddr = top_addr;
                                n_state     = lsr_pkg::ST_RD_RESP;
                            end
                        end
                        lsr_pkg::CMD_REVERSE: begin
                            if (r_count >= CW'(2)) begin
                                n_lo    = '0;
                                n_hi    = top_addr;
                                n_state = lsr_pkg::ST_REV_RD_LO;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        lsr_pkg::CMD_DUMP: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = lsr_pkg::STAT_EMPTY;
                            end else begin
                                n_lo    = '0;
                                n_state = lsr_pkg::ST_DUMP;
                            end
                        end
                        default: begin
                            // size and unused codes: report the fill level only
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            lsr_pkg::ST_RD_RESP: begin
                n_valid = 1'b1;
                n_data  = i_mem_rdata;
                n_state = lsr_pkg::ST_IDLE;
            end
            lsr_pkg::ST_REV_RD_LO: begin
                o_mem_raddr = r_lo;
                n_state     = lsr_pkg::ST_REV_RD_HI;
            end
            lsr_pkg::ST_REV_RD_HI: begin
                o_mem_raddr = r_hi;
                n_tmp       = i_mem_rdata;
                n_state     = lsr_pkg::ST_REV_WR_LO;
            end
            lsr_pkg::ST_REV_WR_LO: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_lo;
                o_mem_wdata = i_mem_rdata;
                n_state     = lsr_pkg::ST_REV_WR_HI;
            end
            lsr_pkg::ST_REV_WR_HI: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_hi;
                o_mem_wdata = r_tmp;
                n_lo        = lo_inc;
                n_hi        = hi_dec;
                if (lo_inc < hi_dec) begin
                    n_state = lsr_pkg::ST_REV_RD_LO;
                end else begin
                    n_valid = 1'b1;
                    n_state = lsr_pkg::ST_IDLE;
                end
            end
            lsr_pkg::ST_DUMP: begin
                // read ahead one entry; the previous read lands this cycle
                o_mem_raddr = r_lo;
                n_pend      = 1'b1;
                n_pidx      = r_lo;
                if (r_pend) begin
                    n_valid = 1'b1;
                    n_data  = i_mem_rdata;
                    n_idx   = r_pidx;
                    n_last  = 1'b0;
                end
                if (r_lo == top_addr) begin
                    n_state = lsr_pkg::ST_DUMP_LAST;
                end else begin
                    n_lo = lo_inc;
                end
            end
            lsr_pkg::ST_DUMP_LAST: begin
                n_valid = 1'b1;
                n_data  = i_mem_rdata;
                n_idx   = r_pidx;
                n_state = lsr_pkg::ST_IDLE;
            end
            default: begin
                n_state = lsr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != lsr_pkg::ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_data_word    = r_data;
    assign o_entry_index  = r_idx;
    assign o_fill_level   = r_fill;
    assign o_status       = r_status;
    assign o_last_result  = r_last;

endmodule

`default_nettype wire
